/* rtl/core/fvc_pkg.sv */
package fvc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 5;
  localparam int unsigned SeqW     = 6;
  localparam int unsigned TypeW    = 5;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [ByteW-1:0] CrcPoly     = 8'h07;
  localparam logic [ByteW-1:0] CrcInit     = 8'h00;
  localparam logic [ByteW-1:0] IndexMax    = 8'hFF;
  localparam logic [ByteW-1:0] HdrSkip     = 8'd3;
  localparam logic [ByteW-1:0] MarkerReset = 8'd126;
  localparam logic [ByteW-1:0] MinLenReset = 8'd14;

  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_SHORT  = 3'd1,
    ERR_MARKER = 3'd2,
    ERR_TRUNC  = 3'd3,
    ERR_CRC    = 3'd4
  } err_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_MARKER    = 1'b0,
    REG_MIN_FRAME_BYTES = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] min_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             last_byte;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             payload_valid;
    logic             verdict_valid;
    logic             frame_ok;
    err_e             error_code;
    logic [LenW-1:0]  data_length;
    logic [SeqW-1:0]  sequence_res;
    logic [TypeW-1:0] frame_type;
    logic [ByteW-1:0] crc_received;
  } result_t;

  // One byte through CRC-8, MSB first, no reflection.
  function automatic logic [ByteW-1:0] crc8_feed(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] v;
    v = crc ^ b;
    for (int k = 0; k < ByteW; k++) begin
      v = v[ByteW-1] ? ((v << 1) ^ CrcPoly) : (v << 1);
    end
    return v;
  endfunction

endpackage

/* rtl/core/fvc_in_if.sv */
interface fvc_in_if import fvc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  logic             last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface

/* rtl/core/fvc_out_if.sv */
interface fvc_out_if import fvc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] payload_byte;
  logic             payload_valid;
  logic             verdict_valid;
  logic             frame_ok;
  logic [2:0]       error_code;
  logic [LenW-1:0]  data_length;
  logic [SeqW-1:0]  sequence_res;
  logic [TypeW-1:0] frame_type;
  logic [ByteW-1:0] crc_received;

  modport source (
    output valid, output payload_byte, output payload_valid, output verdict_valid,
    output frame_ok, output error_code, output data_length, output sequence_res,
    output frame_type, output crc_received, input ready
  );
  modport sink (
    input valid, input payload_byte, input payload_valid, input verdict_valid,
    input frame_ok, input error_code, input data_length, input sequence_res,
    input frame_type, input crc_received, output ready
  );
endinterface

/* rtl/core/fvc_in_stage.sv */
module fvc_in_stage import fvc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fvc_in_if.sink    rx_i,
  input  logic      advance_i,
  output logic      valid_o,
  output item_t     item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  // Refill in the same cycle the held byte moves on.
  assign rx_i.ready = !valid_q || advance_i;
  assign take       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (advance_i) valid_d = 1'b0;
    if (take)      valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{rx_byte: rx_i.rx_byte, last_byte: rx_i.last_byte};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/core/fvc_frame_core.sv */
module fvc_frame_core import fvc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t res_o
);

  logic [ByteW-1:0] byte_index_q, byte_index_d;
  logic [ByteW-1:0] crc_running_q, crc_running_d;
  logic             marker_good_q, marker_good_d;
  logic [ByteW-1:0] header_first_q, header_first_d;
  logic [ByteW-1:0] header_second_q, header_second_d;
  logic             crc_seen_q, crc_seen_d;
  logic             crc_match_q, crc_match_d;
  logic [ByteW-1:0] crc_byte_kept_q, crc_byte_kept_d;

  logic [ByteW-1:0] b;
  logic [ByteW-1:0] crc_end;
  logic [ByteW-1:0] count;
  logic [LenW-1:0]  len;
  err_e             err;

  assign b       = item_i.rx_byte;
  assign len     = header_first_q[ByteW-1 -: LenW];
  assign crc_end = {{(ByteW-LenW){1'b0}}, len} + HdrSkip;
  assign count   = (byte_index_q != IndexMax) ? byte_index_q + 8'd1 : IndexMax;

  always_comb begin
    // Frame state after this byte
    crc_running_d   = crc_running_q;
    marker_good_d   = marker_good_q;
    header_first_d  = header_first_q;
    header_second_d = header_second_q;
    crc_seen_d      = crc_seen_q;
    crc_match_d     = crc_match_q;
    crc_byte_kept_d = crc_byte_kept_q;
    res_o           = '0;
    res_o.error_code = ERR_OK;

    if (byte_index_q == 8'd0) begin
      crc_running_d   = CrcInit;
      header_first_d  = '0;
      header_second_d = '0;
      crc_seen_d      = 1'b0;
      crc_match_d     = 1'b0;
      crc_byte_kept_d = '0;
      marker_good_d   = (b == cfg_i.start_marker);
    end else if (byte_index_q == 8'd1) begin
      header_first_d = b;
      crc_running_d  = crc8_feed(crc_running_q, b);
    end else if (byte_index_q == 8'd2) begin
      header_second_d = b;
      crc_running_d   = crc8_feed(crc_running_q, b);
    end else if (byte_index_q < crc_end) begin
      res_o.payload_byte  = b;
      res_o.payload_valid = 1'b1;
      crc_running_d       = crc8_feed(crc_running_q, b);
    end else if (byte_index_q == crc_end) begin
      crc_seen_d      = 1'b1;
      crc_byte_kept_d = b;
      crc_match_d     = (b == crc_running_q);
    end

    if (count < cfg_i.min_frame_bytes) err = ERR_SHORT;
    else if (!marker_good_d)            err = ERR_MARKER;
    else if (!crc_seen_d)               err = ERR_TRUNC;
    else if (!crc_match_d)              err = ERR_CRC;
    else                                err = ERR_OK;

    if (item_i.last_byte) begin
      res_o.verdict_valid = 1'b1;
      res_o.frame_ok      = (err == ERR_OK);
      res_o.error_code    = err;
      res_o.data_length   = header_first_d[ByteW-1 -: LenW];
      res_o.sequence_res  = {header_first_d[2:0], header_second_d[7:5]};
      res_o.frame_type    = header_second_d[TypeW-1:0];
      res_o.crc_received  = crc_byte_kept_d;
      byte_index_d        = '0;
    end else begin
      byte_index_d = count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q    <= '0;
      crc_running_q   <= CrcInit;
      marker_good_q   <= 1'b0;
      header_first_q  <= '0;
      header_second_q <= '0;
      crc_seen_q      <= 1'b0;
      crc_match_q     <= 1'b0;
      crc_byte_kept_q <= '0;
    end else if (fire_i) begin
      byte_index_q <= byte_index_d;
      if (item_i.last_byte) begin
        crc_running_q   <= CrcInit;
        marker_good_q   <= 1'b0;
        header_first_q  <= '0;
        header_second_q <= '0;
        crc_seen_q      <= 1'b0;
        crc_match_q     <= 1'b0;
        crc_byte_kept_q <= '0;
      end else begin
        crc_running_q   <= crc_running_d;
        marker_good_q   <= marker_good_d;
        header_first_q  <= header_first_d;
        header_second_q <= header_second_d;
        crc_seen_q      <= crc_seen_d;
        crc_match_q     <= crc_match_d;
        crc_byte_kept_q <= crc_byte_kept_d;
      end
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.last_byte |=> byte_index_q == 8'd0 && crc_running_q == CrcInit)
    else $error("frame state not cleared after last byte");

  a_index_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !item_i.last_byte && byte_index_q != IndexMax
    |=> byte_index_q == $past(byte_index_q) + 8'd1)
    else $error("byte index did not advance");

  a_index_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !item_i.last_byte && byte_index_q == IndexMax |=> byte_index_q == IndexMax)
    else $error("byte index wrapped");

  a_verdict_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> res_o.verdict_valid == item_i.last_byte
    && (res_o.frame_ok == (res_o.verdict_valid && res_o.error_code == ERR_OK)))
    else $error("verdict fields inconsistent");

  a_no_payload_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_index_q < HdrSkip |-> !res_o.payload_valid)
    else $error("header byte flagged as data");

endmodule

/* rtl/core/fvc_out_stage.sv */
module fvc_out_stage import fvc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  result_t   res_i,
  output logic      can_take_o,
  fvc_out_if.source res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign can_take_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (res_o.ready) valid_d = 1'b0;
    if (load_i)      valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.payload_byte  = res_q.payload_byte;
  assign res_o.payload_valid = res_q.payload_valid;
  assign res_o.verdict_valid = res_q.verdict_valid;
  assign res_o.frame_ok      = res_q.frame_ok;
  assign res_o.error_code    = res_q.error_code;
  assign res_o.data_length   = res_q.data_length;
  assign res_o.sequence_res  = res_q.sequence_res;
  assign res_o.frame_type    = res_q.frame_type;
  assign res_o.crc_received  = res_q.crc_received;

endmodule

/* rtl/core/frame_validator_crc8_unit.sv */
// Frame checker with CRC-8 (poly 0x07, init 0, MSB first) over the header and
// data bytes. Takes one captured byte per cycle and returns exactly one result
// per byte via the input and result registers; the whole per-byte update,
// including the byte-wide CRC XOR network, sits between them, so the sustained
// rate is one byte per clock as long as the result side keeps taking. Data
// bytes come out with payload_valid set; the byte marked last carries the
// verdict (too short, bad marker, truncated, CRC mismatch, checked in that
// order) and the header fields, and the next byte starts a new frame. The
// user must write start_marker (index 0) and min_frame_bytes (index 1) only
// while no frame byte is in flight; the block does not enforce this.
module frame_validator_crc8_unit import fvc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  fvc_in_if.sink              rx_i,
  fvc_out_if.source           res_o
);

  cfg_t    cfg_q, cfg_d;
  logic    item_valid;
  item_t   item;
  logic    can_take;
  logic    advance;
  result_t res_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_START_MARKER:    cfg_d.start_marker    = cfg_wdata_i;
        REG_MIN_FRAME_BYTES: cfg_d.min_frame_bytes = cfg_wdata_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{start_marker: MarkerReset, min_frame_bytes: MinLenReset};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Byte moves from the input register into the result register.
  assign advance = item_valid && can_take;

  fvc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_i),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  fvc_frame_core u_frame_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .fire_i (advance),
    .item_i (item),
    .res_o  (res_d)
  );

  fvc_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .res_i      (res_d),
    .can_take_o (can_take),
    .res_o      (res_o)
  );

endmodule
